### hdl/bfa_pkg.sv
// Shared types and codes of the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  // Configuration register indexes
  localparam logic REG_REGION_BASE = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [31:0] free_address;
  } bfa_req_t;

  typedef struct packed {
    logic [31:0] frame_address;
    logic [1:0]  status;
    logic [13:0] free_frames;
  } bfa_rsp_t;

endpackage

`default_nettype wire

### hdl/bitmap_frame_allocator.sv
// Bitmap first-fit page frame allocator with its sequencer and bitmap memory.
//
// Use: requests arrive on the in channel (valid/ready, payload bfa_req_t) and
// each request gives exactly one result on the out channel (valid/ready,
// payload bfa_rsp_t). region_base is to be written through the APB-style port
// only while the block is idle; the block does not enforce this. pready is
// always high and a read returns the register. The block works on one item at
// a time. Subtract/compare logic and a single-port bitmap memory of one 32-bit
// word per 32 frames do the work. An allocate reads bitmap words one at a time,
// starting at the lowest word that may still hold a free frame; a full allocate
// reads none. A free derives the frame index from a reciprocal estimate, which
// may need two correction steps when FRAME_BYTES is not a power of two. An
// address out of range is answered without a bitmap access. The block is ready
// again in the cycle after the result is loaded.
// The result sits in an output register; while a stalled receiver holds it
// there, the block waits before it loads the next result.
// After reset the block clears its ceil(NUM_FRAMES/32) bitmap words (256 by
// default), one word a cycle, and is not ready meanwhile.
`default_nettype none

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES  = 8192,
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire bfa_req_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output bfa_rsp_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned MAP_WORDS = (NUM_FRAMES + 31) / 32;
  localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned IXW       = WAW + 5;
  localparam int unsigned QW        = $clog2(NUM_FRAMES);
  localparam int unsigned CW        = $clog2(NUM_FRAMES + 1);
  localparam int unsigned FBW       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned MW        = QW + FBW;
  localparam logic [63:0] LIMIT64   = 64'(NUM_FRAMES) * 64'(FRAME_BYTES);
  localparam int unsigned SHK       = FBW - 1;
  localparam int unsigned HW        = QW + 1;
  localparam int unsigned PW        = 2 * HW + 1;
  localparam logic [63:0] RECIP     = (64'd1 << (SHK + HW)) / 64'(FRAME_BYTES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FCHK  = 4'd2;
  localparam logic [3:0] S_FLIM  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_FADR  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_ARD   = 4'd8;
  localparam logic [3:0] S_ASCAN = 4'd9;
  localparam logic [3:0] S_AMUL  = 4'd10;
  localparam logic [3:0] S_AADD  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_DMUL  = 4'd13;
  localparam logic [3:0] S_DSUB  = 4'd14;
  localparam logic [3:0] S_DFIX  = 4'd15;

  logic [3:0]      state_q, state_d;
  logic [WAW-1:0]  ptr_q, ptr_d;
  logic [WAW-1:0]  hint_q, hint_d;
  logic [CW-1:0]   used_q, used_d;
  logic [IXW-1:0]  idx_q, idx_d;
  logic [31:0]     rem_q, rem_d;
  logic [32:0]     dsr_q, dsr_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     prod_q, prod_d;
  logic [31:0]     faddr_q, faddr_d;
  logic [1:0]      sts_q, sts_d;
  logic [31:0]     base_q;
  logic            out_valid_q;
  bfa_rsp_t        out_q;

  logic [31:0]     mem [MAP_WORDS];
  logic [31:0]     rdata_q;
  logic            mem_we;
  logic [31:0]     mem_wdata;

  logic [32:0]     diff;
  logic [32:0]     sub_res;
  logic            sub_ge;
  logic [31:0]     zero_oh;
  logic [4:0]      zero_pos;
  logic [31:0]     bit_mask;
  logic            bit_set;
  logic [MW-1:0]   mul;
  logic [HW-1:0]   off_hi;
  logic [PW-1:0]   qprod;
  logic [IXW-1:0]  q_est;
  logic            slot_free;
  logic [CW-1:0]   free_cnt;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REGION_BASE) ? base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_REGION_BASE) begin
      base_q <= pwdata;
    end
  end

  // Bitmap memory, one port addressed by the sequencer pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= mem_wdata;
    end
    rdata_q <= mem[ptr_q];
  end

  // Subtractors and compare: the lower range check and the division
  always_comb begin
    diff    = {1'b0, addr_q} - {1'b0, base_q};
    sub_res = {1'b0, rem_q} - dsr_q;
    sub_ge  = ({1'b0, rem_q} >= dsr_q);
  end

  // Lowest clear bit of the word just read, the frame's bit mask and byte offset
  always_comb begin
    zero_oh  = ~rdata_q & (rdata_q + 32'd1);
    zero_pos = 5'd0;
    for (int j = 0; j < 32; j++) begin
      if (zero_oh[j]) begin
        zero_pos = zero_pos | 5'(j);
      end
    end
    bit_mask = 32'd1 << idx_q[4:0];
    bit_set  = |(rdata_q & bit_mask);
    mul      = MW'(idx_q[QW-1:0]) * MW'(FRAME_BYTES);
  end

  // The offset scaled down to a few bits above the frame count, times a
  // constant reciprocal, never overshoots the frame index and falls short of
  // it by at most two.
  always_comb begin
    off_hi = HW'(rem_q >> SHK);
    qprod  = PW'(off_hi) * PW'(RECIP[HW:0]);
    q_est  = IXW'(qprod >> HW);
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign free_cnt  = CW'(NUM_FRAMES) - used_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    hint_d    = hint_q;
    used_d    = used_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    addr_d    = addr_q;
    prod_d    = prod_q;
    faddr_d   = faddr_q;
    sts_d     = sts_q;
    mem_we    = 1'b0;
    mem_wdata = 32'd0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_q == WAW'(MAP_WORDS - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + WAW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d  = in_data_i.free_address;
          faddr_d = 32'd0;
          if (in_data_i.opcode == OP_FREE) begin
            state_d = S_FCHK;
          end else if (used_q == CW'(NUM_FRAMES)) begin
            sts_d   = ST_FULL;
            state_d = S_OUT;
          end else begin
            ptr_d   = hint_q;
            state_d = S_ARD;
          end
        end
      end
      S_FCHK: begin
        if (diff[32]) begin
          sts_d   = ST_IGNORED;
          state_d = S_OUT;
        end else begin
          rem_d   = diff[31:0];
          state_d = S_FLIM;
        end
      end
      S_FLIM: begin
        if ({1'b0, rem_q} >= LIMIT64[32:0]) begin
          sts_d   = ST_IGNORED;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        idx_d   = q_est;
        state_d = S_DMUL;
      end
      S_DMUL: begin
        dsr_d   = {1'b0, 32'(mul)};
        state_d = S_DSUB;
      end
      S_DSUB: begin
        rem_d   = sub_res[31:0];
        dsr_d   = 33'(FRAME_BYTES);
        state_d = S_DFIX;
      end
      S_DFIX: begin
        // Step the estimate up while a whole frame is left over.
        if (sub_ge) begin
          rem_d = sub_res[31:0];
          idx_d = idx_q + IXW'(1);
        end else begin
          state_d = S_FADR;
        end
      end
      S_FADR: begin
        ptr_d   = idx_q[IXW-1:5];
        state_d = S_FRD;
      end
      S_FRD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        if (bit_set) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~bit_mask;
          used_d    = used_q - CW'(1);
          if (ptr_q < hint_q) begin
            hint_d = ptr_q;
          end
        end
        sts_d   = ST_FREED;
        state_d = S_OUT;
      end
      S_ARD: begin
        state_d = S_ASCAN;
      end
      S_ASCAN: begin
        // Every word below the hint is full, so the first word with a
        // clear bit holds the lowest free frame.
        if (rdata_q == 32'hFFFF_FFFF) begin
          ptr_d   = ptr_q + WAW'(1);
          state_d = S_ARD;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | zero_oh;
          used_d    = used_q + CW'(1);
          hint_d    = ptr_q;
          idx_d     = {ptr_q, zero_pos};
          state_d   = S_AMUL;
        end
      end
      S_AMUL: begin
        prod_d  = 32'(mul);
        state_d = S_AADD;
      end
      S_AADD: begin
        faddr_d = base_q + prod_q;
        sts_d   = ST_ALLOCATED;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      hint_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      if (state_q == S_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    addr_q  <= addr_d;
    prod_q  <= prod_d;
    faddr_q <= faddr_d;
    sts_q   <= sts_d;
    if (state_q == S_OUT && slot_free) begin
      out_q.frame_address <= faddr_q;
      out_q.status        <= sts_q;
      out_q.free_frames   <= 14'(free_cnt);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count of used frames can never pass the number of frames.
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(NUM_FRAMES))
    else $error("used frame count exceeds the number of frames");

  // A full answer can only be given with no free frame left.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |-> out_data_o.free_frames == 14'd0)
    else $error("full status reported with free frames left");

  // The count changes only on a bitmap update.
  a_used_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> ($past(state_q) == S_ASCAN || $past(state_q) == S_FWR))
    else $error("used frame count changed outside a bitmap update");

  // No item is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("ready while the bitmap is being cleared");

endmodule

`default_nettype wire
